[hw/rtl/ced_pkg.sv]
// ----------------------------------------------------------------------------
// C string escape decoder package
// Types and constants shared by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ced_pkg;

    // Largest number of results that one input byte can cause.
    localparam int MaxResults = 4;
    // Depth of the queue between the front and back ends.
    localparam int QueueDepth = 4;

    localparam int SlotW  = $clog2(MaxResults);
    localparam int CountW = $clog2(MaxResults + 1);
    localparam int PtrW   = $clog2(QueueDepth);
    localparam int FillW  = $clog2(QueueDepth + 1);

    // Decoder phase.
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_STR  = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX0 = 3'd3,
        PH_HEX1 = 3'd4,
        PH_OCT  = 3'd5
    } t_phase;

    // One result item.
    typedef struct packed {
        logic       warn;
        logic       done;
        logic       valid;
        logic [7:0] data;
    } t_result;

    // All results caused by one input byte, slot 0 first.
    typedef struct packed {
        logic [CountW-1:0]          cnt;
        t_result [MaxResults-1:0]   res;
    } t_group;

endpackage

[hw/rtl/c_string_escape_decoder_unit.sv]
// Each result group is registered in the queue before it reaches the master side.
// The input takes one byte per cycle while the queue is not full. The output moves
// one result per cycle while the consumer is ready; a byte causes at most four results.
// A four-entry group queue lets the input keep running while the output drains.
// Reset (i_rst_n low, synchronous) returns the decoder to idle and empties the queue.
// ----------------------------------------------------------------------------
// C string escape decoder unit
// Decodes a byte stream of double-quoted C strings into the bytes they denote.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c_string_escape_decoder_unit
    import ced_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Slave side: one transaction per input byte.
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    // Master side: one transaction per result.
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] o_m_axis_tuser,   // [0] byte_valid, [1] warn
    output logic       o_m_axis_tlast    // done_res
);

    // The front end classifies each byte against the escape state and builds
    // the whole group of results that it causes in the same cycle. Groups with
    // at least one result are written to the queue at the accepting edge.
    logic    q_full, q_empty, q_push, q_pop;
    t_group  push_group, head_group;
    t_result res;

    ced_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_byte   (i_s_axis_tdata),
        .i_q_full (q_full),
        .o_ready  (o_s_axis_tready),
        .o_push   (q_push),
        .o_group  (push_group)
    );

    // The queue parts the two sides, so the input is still taken while a
    // finished result waits for the downstream consumer, until the queue is full.
    ced_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_group (push_group),
        .i_pop   (q_pop),
        .o_head  (head_group),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // The back end hands out the head group's results in slot order and
    // releases the group after its last result has been taken.
    ced_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_group),
        .i_empty (q_empty),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_res   (res),
        .o_pop   (q_pop)
    );

    assign o_m_axis_tdata = res.data;
    assign o_m_axis_tuser = {res.warn, res.valid};
    assign o_m_axis_tlast = res.done;

endmodule

[hw/rtl/ced_front.sv]
// ----------------------------------------------------------------------------
// C string escape decoder front end
// Accepts input bytes, tracks the escape state and builds the result group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ced_front
    import ced_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  logic [7:0] i_byte,
    input  logic   i_q_full,
    output logic   o_ready,
    output logic   o_push,
    output t_group o_group
);

    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChZero   = 8'h30;
    localparam logic [7:0] ChSeven  = 8'h37;
    localparam logic [7:0] ChA      = 8'h61;
    localparam logic [7:0] ChB      = 8'h62;
    localparam logic [7:0] ChF      = 8'h66;
    localparam logic [7:0] ChN      = 8'h6E;
    localparam logic [7:0] ChR      = 8'h72;
    localparam logic [7:0] ChT      = 8'h74;
    localparam logic [7:0] ChV      = 8'h76;
    localparam logic [7:0] ChX      = 8'h78;

    // Returns {is_hex, value}.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic t_result mk_res(input logic [7:0] d, input logic w);
        t_result r;
        r.data  = d;
        r.valid = 1'b1;
        r.done  = 1'b0;
        r.warn  = w;
        return r;
    endfunction

    t_phase       r_phase, n_phase;
    logic [8:0]   r_val, n_val;
    logic [1:0]   r_cnt, n_cnt;

    logic         accept;
    logic [7:0]   b, lb;
    logic [4:0]   hx;
    logic         odig;
    t_result      pb_res;
    logic         pb_has;
    t_phase       pb_phase;
    logic [8:0]   oct_val;
    logic [1:0]   oct_cnt;
    t_group       grp;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign b       = i_byte;
    // Only upper-case letters are folded; every other byte passes unchanged.
    assign lb      = (b >= 8'h41 && b <= 8'h5A) ? {b[7:6], 1'b1, b[4:0]} : b;
    assign hx      = hex_digit(b);
    assign odig    = (b >= ChZero) && (b <= ChSeven);
    assign oct_val = {r_val[5:0], b[2:0]};
    assign oct_cnt = r_cnt + 2'd1;

    // A byte inside the string, outside any escape.
    always_comb begin
        pb_res = '0;
        if (b == ChQuote || b == 8'd0) begin
            pb_res.done = 1'b1;
            pb_has      = 1'b1;
            pb_phase    = PH_IDLE;
        end else if (b == ChBslash) begin
            pb_has   = 1'b0;
            pb_phase = PH_ESC;
        end else begin
            pb_res   = mk_res(b, 1'b0);
            pb_has   = 1'b1;
            pb_phase = PH_STR;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_val   = r_val;
        n_cnt   = r_cnt;
        grp     = '0;
        unique case (r_phase)
            PH_STR: begin
                grp.res[0] = pb_res;
                grp.cnt    = pb_has ? 3'd1 : 3'd0;
                n_phase    = pb_phase;
            end
            PH_ESC: begin
                n_phase = PH_STR;
                grp.cnt = 3'd1;
                unique case (lb)
                    ChBslash, ChQuote: grp.res[0] = mk_res(b, 1'b0);
                    ChA: grp.res[0] = mk_res(8'd7, 1'b0);
                    ChB: grp.res[0] = mk_res(8'd8, 1'b0);
                    ChF: grp.res[0] = mk_res(8'd12, 1'b0);
                    ChN: grp.res[0] = mk_res(8'd10, 1'b0);
                    ChR: grp.res[0] = mk_res(8'd13, 1'b0);
                    ChT: grp.res[0] = mk_res(8'd9, 1'b0);
                    ChV: grp.res[0] = mk_res(8'd11, 1'b0);
                    ChX: begin
                        // Keep the x as written, for the case of no digit.
                        grp.cnt = 3'd0;
                        n_val   = {1'b0, b};
                        n_phase = PH_HEX0;
                    end
                    default: begin
                        if (odig) begin
                            grp.cnt = 3'd0;
                            n_val   = {6'd0, b[2:0]};
                            n_cnt   = 2'd1;
                            n_phase = PH_OCT;
                        end else begin
                            grp.res[0] = mk_res(ChBslash, 1'b1);
                            grp.res[1] = pb_res;
                            grp.cnt    = pb_has ? 3'd2 : 3'd1;
                            n_phase    = pb_phase;
                        end
                    end
                endcase
            end
            PH_HEX0: begin
                if (hx[4]) begin
                    n_val   = {5'd0, hx[3:0]};
                    n_phase = PH_HEX1;
                end else begin
                    grp.res[0] = mk_res(ChBslash, 1'b1);
                    grp.res[1] = mk_res(r_val[7:0], 1'b0);
                    grp.res[2] = pb_res;
                    grp.cnt    = pb_has ? 3'd3 : 3'd2;
                    n_val      = '0;
                    n_phase    = pb_phase;
                end
            end
            PH_HEX1: begin
                n_val = '0;
                if (hx[4]) begin
                    grp.res[0] = mk_res({r_val[3:0], hx[3:0]}, 1'b0);
                    grp.cnt    = 3'd1;
                    n_phase    = PH_STR;
                end else begin
                    grp.res[0] = mk_res(r_val[7:0], 1'b0);
                    grp.res[1] = pb_res;
                    grp.cnt    = pb_has ? 3'd2 : 3'd1;
                    n_phase    = pb_phase;
                end
            end
            PH_OCT: begin
                if (odig) begin
                    if (oct_cnt == 2'd3 || oct_cnt == 2'd0) begin
                        if (!oct_val[8]) begin
                            grp.res[0] = mk_res(oct_val[7:0], 1'b0);
                            grp.cnt    = 3'd1;
                        end else begin
                            // Out of range: put the escape back as written.
                            grp.res[0] = mk_res(ChBslash, 1'b1);
                            grp.res[1] = mk_res({5'b00110, oct_val[8:6]}, 1'b0);
                            grp.res[2] = mk_res({5'b00110, oct_val[5:3]}, 1'b0);
                            grp.res[3] = mk_res({5'b00110, oct_val[2:0]}, 1'b0);
                            grp.cnt    = 3'd4;
                        end
                        n_val   = '0;
                        n_cnt   = '0;
                        n_phase = PH_STR;
                    end else begin
                        n_val = oct_val;
                        n_cnt = oct_cnt;
                    end
                end else begin
                    grp.res[0] = mk_res(r_val[7:0], 1'b0);
                    grp.res[1] = pb_res;
                    grp.cnt    = pb_has ? 3'd2 : 3'd1;
                    n_val      = '0;
                    n_cnt      = '0;
                    n_phase    = pb_phase;
                end
            end
            default: begin
                if (b == ChQuote) begin
                    n_phase = PH_STR;
                end else begin
                    grp.res[0].done = 1'b1;
                    grp.cnt         = 3'd1;
                    n_phase         = PH_IDLE;
                end
            end
        endcase
    end

    assign o_group = grp;
    assign o_push  = accept && (grp.cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_val   <= '0;
            r_cnt   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_val   <= n_val;
            r_cnt   <= n_cnt;
        end
    end

endmodule

[hw/rtl/ced_queue.sv]
// ----------------------------------------------------------------------------
// C string escape decoder queue
// Short register queue of result groups between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ced_queue
    import ced_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_group,
    input  logic   i_pop,
    output t_group o_head,
    output logic   o_empty,
    output logic   o_full
);

    t_group           r_mem [QueueDepth];
    logic [PtrW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FillW-1:0] r_fill;

    assign o_empty = (r_fill == '0);
    assign o_full  = (r_fill == FillW'(QueueDepth));
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + FillW'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - FillW'(1);
            end
        end
    end

endmodule

[hw/rtl/ced_back.sv]
// ----------------------------------------------------------------------------
// C string escape decoder back end
// Walks the slots of the head group and hands out one result per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ced_back
    import ced_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_group  i_head,
    input  logic    i_empty,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_pop
);

    logic [SlotW-1:0] r_slot;
    logic             last_slot;

    assign o_valid   = !i_empty;
    assign o_res     = i_head.res[r_slot];
    assign last_slot = ({1'b0, r_slot} + CountW'(1)) == i_head.cnt;
    assign o_pop     = o_valid && i_ready && last_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (o_valid && i_ready) begin
            r_slot <= last_slot ? '0 : r_slot + SlotW'(1);
        end
    end

`ifndef NO_ASSERTIONS
    a_slot_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, r_slot} < i_head.cnt))
        else $error("slot index beyond group count");

    a_group_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (i_head.cnt != '0))
        else $error("empty group in queue");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.done) |-> last_slot)
        else $error("done result is not the last of its group");

    a_slot_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(r_slot))
        else $error("slot moved while stalled");
`endif

endmodule
